### hw/rtl/lmsd_pkg.sv
// lmsd_pkg: shared constants for the LED matrix scan driver.
// Holds the item kind codes, configuration indexes and default geometry.
// No dependencies.
package lmsd_pkg;

    // Geometry defaults: 64 x 32 panel, 1:16 scan
    localparam int PANEL_WIDTH_DEF  = 64;
    localparam int PANEL_HEIGHT_DEF = 32;
    localparam int ROW_PAIRS_DEF    = 16;

    // Item kinds
    localparam logic [1:0] KIND_PIXEL = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;
    localparam logic [1:0] KIND_TICK  = 2'd3;

    // Configuration register indexes
    localparam logic CFG_LATCH_TICKS = 1'b0;
    localparam logic CFG_ON_TICKS    = 1'b1;

    // Configuration reset values
    localparam logic [9:0]  LATCH_TICKS_RST = 10'd10;
    localparam logic [15:0] ON_TICKS_RST    = 16'd50;

    // Pixel colour bits, R G B in bits 0..2
    localparam int PIX_W = 3;

endpackage

### hw/rtl/led_matrix_scan_driver_core.sv
// led_matrix_scan_driver_core: top level of the HUB75-style 1:16 scan driver.
// Depends on lmsd_pkg and lmsd_ram.
//
// Usage
//   Input channel (i_in_valid / o_in_ready) carries one command per transfer:
//   pixel write, clear-and-refresh, start refresh or tick. Every accepted
//   command yields exactly one result transfer (o_res_valid / i_res_ready)
//   carrying the panel pin levels after that command.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes latch_ticks
//   (index 0) and on_ticks (index 1); it is always ready. Write it only while
//   the block is idle.
//   Pipeline: each command passes through the read stage, then the result
//   register. Throughput: one command per cycle while no result is held
//   back and no clear sweep runs. The read stage is set by the
//   framebuffer: a two-read-port RAM with registered read, addressed by
//   the scan position after the command; a write to the pixel being read in
//   the same cycle is forwarded.
//   Clear: the framebuffer is swept one entry per cycle, all PANEL_WIDTH *
//   PANEL_HEIGHT entries (2048 by default), after reset and after every
//   clear command. o_in_ready is low during the sweep; configuration
//   transfers are still taken.
//   Stall: a held result stalls the pipeline; o_in_ready drops only once
//   both the result register and the read stage are full, or in a clear sweep.
module led_matrix_scan_driver_core #(
    parameter int PANEL_WIDTH  = lmsd_pkg::PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = lmsd_pkg::PANEL_HEIGHT_DEF,
    parameter int ROW_PAIRS    = lmsd_pkg::ROW_PAIRS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [6:0]  i_col_x,
    input  logic [5:0]  i_row_y,
    input  logic        i_red_on,
    input  logic        i_green_on,
    input  logic        i_blue_on,
    // result channel
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [5:0]  o_color_pins,
    output logic        o_shift_clock,
    output logic        o_latch_pin,
    output logic        o_blank_pin,
    output logic [3:0]  o_row_address,
    output logic        o_busy_res,
    output logic        o_frame_done,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int DEPTH = PANEL_WIDTH * PANEL_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(PANEL_WIDTH);
    localparam int RW    = $clog2(ROW_PAIRS);
    localparam int YW    = $clog2(PANEL_HEIGHT + ROW_PAIRS) + 1;   // row + ROW_PAIRS fits
    localparam int FW    = YW + CW + 1;                            // full address product
    localparam int PW    = lmsd_pkg::PIX_W;

    // Scan phases
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_LOW   = 3'd1;
    localparam logic [2:0] PH_HIGH  = 3'd2;
    localparam logic [2:0] PH_LATCH = 3'd3;
    localparam logic [2:0] PH_ON    = 3'd4;

    // Read stage: pin levels plus what is needed to build the colour bits
    typedef struct packed {
        logic          shift_clock;
        logic          latch_pin;
        logic          blank_pin;
        logic [3:0]    row_address;
        logic          busy;
        logic          frame_done;
        logic          top_ok;     // shifting and top row on the panel
        logic          bot_ok;     // shifting and bottom row on the panel
        logic          top_hit;    // same-cycle write to the top pixel
        logic          bot_hit;
        logic [PW-1:0] fwd_data;
    } t_stage;

    typedef struct packed {
        logic [5:0] color_pins;
        logic       shift_clock;
        logic       latch_pin;
        logic       blank_pin;
        logic [3:0] row_address;
        logic       busy;
        logic       frame_done;
    } t_result;

    // ---------------- state ----------------
    logic [2:0]    r_phase,      n_phase;
    logic [RW-1:0] r_row,        n_row;
    logic [CW-1:0] r_col,        n_col;
    logic [15:0]   r_timer,      n_timer;
    logic          r_idle_blank, n_idle_blank;
    logic [3:0]    r_addr_out,   n_addr_out;
    logic          r_from_clear, n_from_clear;
    logic          n_done;

    logic [9:0]    r_latch_ticks;
    logic [15:0]   r_on_ticks;

    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    logic          r_s1_valid;
    t_stage        r_s1, n_s1;
    logic          r_res_valid;
    t_result       r_res;

    logic          in_fire;
    logic          s1_adv;
    logic          out_free;

    // ---------------- handshakes ----------------
    assign out_free    = !r_res_valid || i_res_ready;
    assign s1_adv      = r_s1_valid && out_free;
    assign o_in_ready  = !r_clr_busy && (!r_s1_valid || out_free);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch_ticks <= lmsd_pkg::LATCH_TICKS_RST;
            r_on_ticks    <= lmsd_pkg::ON_TICKS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lmsd_pkg::CFG_LATCH_TICKS: r_latch_ticks <= i_cfg_data[9:0];
                lmsd_pkg::CFG_ON_TICKS:    r_on_ticks    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- scan sequencer ----------------
    logic [15:0] latch_eff;
    logic [15:0] on_eff;
    logic        col_last;
    logic        row_last;

    // a zero timing register behaves as one
    assign latch_eff = (r_latch_ticks == '0) ? 16'd1 : 16'(r_latch_ticks);
    assign on_eff    = (r_on_ticks == '0) ? 16'd1 : r_on_ticks;
    assign col_last  = !((CW + 1)'(r_col) + 1'b1 < (CW + 1)'(PANEL_WIDTH));
    assign row_last  = !((RW + 1)'(r_row) + 1'b1 < (RW + 1)'(ROW_PAIRS));

    always_comb begin
        n_phase      = r_phase;
        n_row        = r_row;
        n_col        = r_col;
        n_timer      = r_timer;
        n_idle_blank = r_idle_blank;
        n_addr_out   = r_addr_out;
        n_from_clear = r_from_clear;
        n_done       = 1'b0;
        if (in_fire) begin
            case (i_kind)
                lmsd_pkg::KIND_PIXEL: ;
                lmsd_pkg::KIND_CLEAR, lmsd_pkg::KIND_START: begin
                    // (re)start always goes back to pair 0, column 0
                    n_from_clear = (i_kind == lmsd_pkg::KIND_CLEAR);
                    n_row        = '0;
                    n_col        = '0;
                    n_phase      = PH_LOW;
                    n_timer      = '0;
                end
                lmsd_pkg::KIND_TICK: begin
                    case (r_phase)
                        PH_LOW: n_phase = PH_HIGH;
                        PH_HIGH: begin
                            if (!col_last) begin
                                n_col   = r_col + 1'b1;
                                n_phase = PH_LOW;
                            end else begin
                                n_phase = PH_LATCH;
                                n_timer = latch_eff;
                            end
                        end
                        PH_LATCH: begin
                            if (r_timer > 16'd1) begin
                                n_timer = r_timer - 1'b1;
                            end else begin
                                n_phase    = PH_ON;
                                n_addr_out = 4'(r_row);
                                n_timer    = on_eff;
                            end
                        end
                        PH_ON: begin
                            if (r_timer > 16'd1) begin
                                n_timer = r_timer - 1'b1;
                            end else if (!row_last) begin
                                n_row   = r_row + 1'b1;
                                n_col   = '0;
                                n_phase = PH_LOW;
                                n_timer = '0;
                            end else begin
                                // end of frame; clear-started scans leave LEDs on
                                n_phase      = PH_IDLE;
                                n_timer      = '0;
                                n_idle_blank = !r_from_clear;
                                n_done       = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_row        <= '0;
            r_col        <= '0;
            r_timer      <= '0;
            r_idle_blank <= 1'b1;
            r_addr_out   <= '0;
            r_from_clear <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_row        <= n_row;
            r_col        <= n_col;
            r_timer      <= n_timer;
            r_idle_blank <= n_idle_blank;
            r_addr_out   <= n_addr_out;
            r_from_clear <= n_from_clear;
        end
    end

    // ---------------- framebuffer ----------------
    logic          pix_in_range;
    logic          pix_we;
    logic [AW-1:0] pix_addr;
    logic [FW-1:0] pix_full;
    logic [FW-1:0] top_full;
    logic [FW-1:0] bot_full;
    logic [AW-1:0] top_addr;
    logic [AW-1:0] bot_addr;
    logic [PW-1:0] pix_data;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [PW-1:0] ram_wdata;
    logic [PW-1:0] top_rdata;
    logic [PW-1:0] bot_rdata;

    assign pix_in_range = ({1'b0, i_col_x} < 8'(PANEL_WIDTH))
                       && ({1'b0, i_row_y} < 7'(PANEL_HEIGHT));
    assign pix_we   = in_fire && (i_kind == lmsd_pkg::KIND_PIXEL) && pix_in_range;
    assign pix_full = FW'(i_row_y) * FW'(PANEL_WIDTH) + FW'(i_col_x);
    assign pix_addr = pix_full[AW-1:0];
    assign pix_data = {i_blue_on, i_green_on, i_red_on};

    // read at the scan position this command leaves behind
    assign top_full = FW'(n_row) * FW'(PANEL_WIDTH) + FW'(n_col);
    assign bot_full = (FW'(n_row) + FW'(ROW_PAIRS)) * FW'(PANEL_WIDTH) + FW'(n_col);
    assign top_addr = top_full[AW-1:0];
    assign bot_addr = bot_full[AW-1:0];

    // sweep has the write port to itself
    assign ram_we    = r_clr_busy || pix_we;
    assign ram_waddr = r_clr_busy ? r_clr_addr : pix_addr;
    assign ram_wdata = r_clr_busy ? '0 : pix_data;

    lmsd_ram #(
        .WIDTH (PW),
        .DEPTH (DEPTH)
    ) u_fb (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (top_addr),
        .i_raddr_b (bot_addr),
        .o_rdata_a (top_rdata),
        .o_rdata_b (bot_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (in_fire && (i_kind == lmsd_pkg::KIND_CLEAR)) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // ---------------- read stage ----------------
    logic n_shifting;
    logic n_top_on;
    logic n_bot_on;

    assign n_shifting = n_phase inside {PH_LOW, PH_HIGH};
    assign n_top_on   = YW'(n_row) < YW'(PANEL_HEIGHT);
    assign n_bot_on   = YW'(n_row) + YW'(ROW_PAIRS) < YW'(PANEL_HEIGHT);

    always_comb begin
        n_s1.shift_clock = (n_phase == PH_HIGH);
        n_s1.latch_pin   = (n_phase == PH_LATCH);
        n_s1.blank_pin   = (n_phase == PH_IDLE) ? n_idle_blank : (n_phase != PH_ON);
        n_s1.row_address = n_addr_out;
        n_s1.busy        = (n_phase != PH_IDLE);
        n_s1.frame_done  = n_done;
        // a clear shows an empty store; the sweep has not run yet
        n_s1.top_ok      = n_shifting && n_top_on && (i_kind != lmsd_pkg::KIND_CLEAR);
        n_s1.bot_ok      = n_shifting && n_bot_on && (i_kind != lmsd_pkg::KIND_CLEAR);
        n_s1.top_hit     = pix_we && (pix_addr == top_addr);
        n_s1.bot_hit     = pix_we && (pix_addr == bot_addr);
        n_s1.fwd_data    = pix_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1 <= n_s1;
        end
    end

    // ---------------- result register ----------------
    logic [PW-1:0] top_bits;
    logic [PW-1:0] bot_bits;

    assign top_bits = !r_s1.top_ok ? '0 : (r_s1.top_hit ? r_s1.fwd_data : top_rdata);
    assign bot_bits = !r_s1.bot_ok ? '0 : (r_s1.bot_hit ? r_s1.fwd_data : bot_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (s1_adv) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_res.color_pins  <= {bot_bits, top_bits};
            r_res.shift_clock <= r_s1.shift_clock;
            r_res.latch_pin   <= r_s1.latch_pin;
            r_res.blank_pin   <= r_s1.blank_pin;
            r_res.row_address <= r_s1.row_address;
            r_res.busy        <= r_s1.busy;
            r_res.frame_done  <= r_s1.frame_done;
        end
    end

    assign o_res_valid   = r_res_valid;
    assign o_color_pins  = r_res.color_pins;
    assign o_shift_clock = r_res.shift_clock;
    assign o_latch_pin   = r_res.latch_pin;
    assign o_blank_pin   = r_res.blank_pin;
    assign o_row_address = r_res.row_address;
    assign o_busy_res    = r_res.busy;
    assign o_frame_done  = r_res.frame_done;

    // ---------------- assertions ----------------
    a_clear_starts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && (i_kind == lmsd_pkg::KIND_CLEAR) |=> r_clr_busy && !o_in_ready)
        else $error("clear transfer did not start the framebuffer sweep");

    a_timer_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LATCH || r_phase == PH_ON) |-> r_timer != '0)
        else $error("phase timer empty in a timed phase");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_frame_done |-> !o_busy_res && !o_latch_pin)
        else $error("frame_done reported while scan still running");

    a_pins_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !(o_latch_pin && o_shift_clock) && (o_latch_pin ? o_blank_pin : 1'b1))
        else $error("latch overlaps shifting or an enabled panel");

    a_idle_dark_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_busy_res |-> o_color_pins == '0)
        else $error("colour data driven while idle");

endmodule

### hw/rtl/lmsd_ram.sv
// lmsd_ram: generic simple RAM, one write port, two registered read ports.
// Stand-alone; no package dependencies.
module lmsd_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule
